### src/assert_macros.svh
// Assertion macros shared by the resampler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define LIR_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define LIR_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### src/lir_pkg.sv
// Shared types and constants of the linear interpolation resampler.
`timescale 1ns / 1ps

package lir_pkg;

    localparam int SAMPLE_BITS        = 24;
    localparam int RATIO_BITS         = 22;
    localparam int FRACTION_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH        = 2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [SAMPLE_BITS:0]   diff_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_res;
        logic                          last_res;
    } out_item_t;

    // One classified source sample, handed from the front end to the back end.
    typedef struct packed {
        sample_t s0;
        sample_t s1;
        diff_t   diff;
        logic    fin;
        logic    first;
    } job_t;

    typedef struct packed {
        logic can_push;
        logic has_job;
    } q_stat_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_LOOP,
        B_ADD,
        B_DONE
    } back_state_t;

endpackage

### src/linear_interp_resampler.sv
// A source sample enters the job queue; when the sequencer is free it takes the job, forms each
// output and holds it until the next is formed; an output held as a possible final one waits.
// The sequencer works through the outputs of a source sample one after another and stalls
// while the output slot is full.
// A two-entry job queue lets input acceptance run ahead of the sequencer.
// Reset (rst_n low, asynchronous) clears the run state and sets the ratio to 1.0.
`timescale 1ns / 1ps

module linear_interp_resampler #(
    parameter int FRACTION_BITS = lir_pkg::FRACTION_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lir_pkg::RATIO_BITS-1:0]  cfg_data,
    input  logic                            src_valid,
    output logic                            src_ready,
    input  lir_pkg::in_item_t               src_item,
    output logic                            res_valid,
    input  logic                            res_ready,
    output lir_pkg::out_item_t              res_item
);

    logic                        push;
    logic                        pop;
    lir_pkg::job_t               push_job;
    lir_pkg::job_t               pop_job;
    lir_pkg::q_stat_t            q_stat;
    logic [FRACTION_BITS+5:0]    ratio;

    lir_front #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_item  (src_item),
        .q_stat    (q_stat),
        .push      (push),
        .push_job  (push_job),
        .ratio     (ratio)
    );

    lir_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_stat   (q_stat)
    );

    lir_back #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ratio     (ratio),
        .q_stat    (q_stat),
        .pop_job   (pop_job),
        .pop       (pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

endmodule

### src/lir_front.sv
// Front end: ratio register, run tracking and classification of source samples.
`timescale 1ns / 1ps

module lir_front #(
    parameter int FRACTION_BITS = lir_pkg::FRACTION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lir_pkg::RATIO_BITS-1:0]      cfg_data,
    input  logic                                src_valid,
    output logic                                src_ready,
    input  lir_pkg::in_item_t                   src_item,
    input  lir_pkg::q_stat_t                    q_stat,
    output logic                                push,
    output lir_pkg::job_t                       push_job,
    output logic [FRACTION_BITS+5:0]            ratio
);

    localparam int POS_W = FRACTION_BITS + 6;
    localparam int CMP_W = (lir_pkg::RATIO_BITS > POS_W) ? lir_pkg::RATIO_BITS : POS_W;
    localparam logic [CMP_W-1:0] R_MIN = CMP_W'(1) << (FRACTION_BITS - 5);
    localparam logic [CMP_W-1:0] R_MAX = CMP_W'(1) << (FRACTION_BITS + 5);

    logic [POS_W-1:0]   ratio_reg, ratio_next;
    lir_pkg::sample_t   prev_reg, prev_next;
    logic               first_reg, first_next;
    logic [CMP_W-1:0]   cfg_ext;
    lir_pkg::sample_t   cur;

    assign cfg_ready = 1'b1;
    assign src_ready = q_stat.can_push;
    assign push      = src_valid && src_ready;
    assign ratio     = ratio_reg;
    assign cur       = src_item.sample;
    assign cfg_ext   = CMP_W'(cfg_data);

    // The ratio is stored already clamped to the range 1/32 .. 32.
    always_comb
    begin
        ratio_next = ratio_reg;
        if (cfg_valid)
        begin
            if (cfg_ext < R_MIN)
                ratio_next = POS_W'(R_MIN);
            else if (cfg_ext > R_MAX)
                ratio_next = POS_W'(R_MAX);
            else
                ratio_next = POS_W'(cfg_ext);
        end
    end

    always_comb
    begin
        prev_next  = prev_reg;
        first_next = first_reg;
        push_job.fin   = src_item.last;
        push_job.first = first_reg;
        push_job.s1    = cur;
        if (first_reg)
        begin
            push_job.s0   = cur;
            push_job.diff = '0;
        end
        else
        begin
            push_job.s0   = prev_reg;
            push_job.diff = (lir_pkg::SAMPLE_BITS+1)'(cur)
                          - (lir_pkg::SAMPLE_BITS+1)'(prev_reg);
        end
        if (push)
        begin
            prev_next  = cur;
            first_next = src_item.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg <= POS_W'(1) << FRACTION_BITS;
            prev_reg  <= '0;
            first_reg <= 1'b1;
        end
        else
        begin
            ratio_reg <= ratio_next;
            prev_reg  <= prev_next;
            first_reg <= first_next;
        end
    end

endmodule

### src/lir_queue.sv
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lir_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lir_pkg::job_t     push_job,
    input  logic              pop,
    output lir_pkg::job_t     pop_job,
    output lir_pkg::q_stat_t  q_stat
);

    localparam int DEPTH = lir_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lir_pkg::job_t     entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign q_stat.can_push = (count_reg != CNT_W'(DEPTH));
    assign q_stat.has_job  = (count_reg != '0);
    assign pop_job         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `LIR_ASSERT_IMPLIES(a_no_push_when_full, push, count_reg != CNT_W'(DEPTH), "push into full queue")
    `LIR_ASSERT_IMPLIES(a_no_pop_when_empty, pop, count_reg != '0, "pop from empty queue")

endmodule

### src/lir_back.sv
// Back end: position sequencer, interpolation datapath and output hold stage.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lir_back #(
    parameter int FRACTION_BITS = lir_pkg::FRACTION_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [FRACTION_BITS+5:0]  ratio,
    input  lir_pkg::q_stat_t          q_stat,
    input  lir_pkg::job_t             pop_job,
    output logic                      pop,
    output logic                      res_valid,
    input  logic                      res_ready,
    output lir_pkg::out_item_t        res_item
);

    localparam int POS_W  = FRACTION_BITS + 6;
    localparam int PROD_W = lir_pkg::SAMPLE_BITS + FRACTION_BITS + 2;
    localparam logic [POS_W-1:0]         ONE_POS = POS_W'(1) << FRACTION_BITS;
    localparam logic signed [PROD_W-1:0] HALF    = PROD_W'(1) << (FRACTION_BITS - 1);

    lir_pkg::back_state_t        state_reg, state_next;
    logic [POS_W-1:0]            pos_reg, pos_next;
    lir_pkg::sample_t            s0_reg, s0_next;
    lir_pkg::sample_t            s1_reg, s1_next;
    lir_pkg::diff_t              diff_reg, diff_next;
    logic                        fin_reg, fin_next;
    logic                        phase_b_reg, phase_b_next;
    logic                        gen_any_reg, gen_any_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic                        pend_valid_reg, pend_valid_next;
    lir_pkg::sample_t            pend_reg, pend_next;
    logic                        out_valid_reg, out_valid_next;
    lir_pkg::out_item_t          out_reg, out_next;

    logic signed [FRACTION_BITS:0] frac_s;
    logic signed [PROD_W-1:0]      rounded;
    lir_pkg::sample_t              lerp_val;
    logic                          below_one;
    logic                          slot_free;
    logic                          needs_emit;

    assign res_valid = out_valid_reg;
    assign res_item  = out_reg;
    assign slot_free = !out_valid_reg || res_ready;
    assign below_one = pos_reg < ONE_POS;
    assign frac_s    = signed'({1'b0, pos_reg[FRACTION_BITS-1:0]});

    // Round half up, then take the floor; the sum always fits the sample width.
    assign rounded  = prod_reg + HALF;
    assign lerp_val = s0_reg + lir_pkg::sample_t'(rounded[FRACTION_BITS +: lir_pkg::SAMPLE_BITS]);

    // A finished job flushes the held output unless it may still be the final one.
    assign needs_emit = pend_valid_reg && (fin_reg || (gen_any_reg && below_one));

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        s0_next         = s0_reg;
        s1_next         = s1_reg;
        diff_next       = diff_reg;
        fin_next        = fin_reg;
        phase_b_next    = phase_b_reg;
        gen_any_next    = gen_any_reg;
        prod_next       = prod_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        out_next        = out_reg;
        pop             = 1'b0;

        case (state_reg)
            lir_pkg::B_IDLE:
            begin
                if (q_stat.has_job)
                begin
                    pop          = 1'b1;
                    s0_next      = pop_job.s0;
                    s1_next      = pop_job.s1;
                    diff_next    = pop_job.diff;
                    fin_next     = pop_job.fin;
                    phase_b_next = pop_job.first;
                    gen_any_next = 1'b0;
                    if (pop_job.first)
                    begin
                        pos_next   = '0;
                        state_next = pop_job.fin ? lir_pkg::B_LOOP : lir_pkg::B_DONE;
                    end
                    else
                        state_next = lir_pkg::B_LOOP;
                end
            end

            lir_pkg::B_LOOP:
            begin
                if (below_one)
                begin
                    prod_next  = PROD_W'(frac_s) * PROD_W'(diff_reg);
                    pos_next   = pos_reg + ratio;
                    state_next = lir_pkg::B_ADD;
                end
                else if (!phase_b_reg)
                begin
                    pos_next = pos_reg - ONE_POS;
                    if (fin_reg)
                    begin
                        // Past the final sample the run holds its last value.
                        phase_b_next = 1'b1;
                        s0_next      = s1_reg;
                        diff_next    = '0;
                    end
                    else
                        state_next = lir_pkg::B_DONE;
                end
                else
                    state_next = lir_pkg::B_DONE;
            end

            lir_pkg::B_ADD:
            begin
                if (!pend_valid_reg || slot_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next      = 1'b1;
                        out_next.sample_res = pend_reg;
                        out_next.last_res   = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_next       = lerp_val;
                    gen_any_next    = 1'b1;
                    state_next      = lir_pkg::B_LOOP;
                end
            end

            lir_pkg::B_DONE:
            begin
                if (!needs_emit || slot_free)
                begin
                    if (needs_emit)
                    begin
                        out_valid_next      = 1'b1;
                        out_next.sample_res = pend_reg;
                        out_next.last_res   = fin_reg;
                        pend_valid_next     = 1'b0;
                    end
                    if (fin_reg)
                        pos_next = '0;
                    state_next = lir_pkg::B_IDLE;
                end
            end

            default:
                state_next = lir_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lir_pkg::B_IDLE;
            pos_reg        <= '0;
            fin_reg        <= 1'b0;
            phase_b_reg    <= 1'b0;
            gen_any_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            fin_reg        <= fin_next;
            phase_b_reg    <= phase_b_next;
            gen_any_reg    <= gen_any_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_reg   <= s0_next;
        s1_reg   <= s1_next;
        diff_reg <= diff_next;
        prod_reg <= prod_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    `LIR_ASSERT_IMPLIES(a_gap_needs_hold, (state_reg == lir_pkg::B_IDLE) && !below_one, pend_valid_reg, "position beyond next sample without a held output")
    `LIR_ASSERT_IMPLIES(a_tail_is_flat, phase_b_reg && (state_reg == lir_pkg::B_ADD), diff_reg == '0, "tail repeat with nonzero slope")

endmodule
